FILE: sv/stable_priority_queue_core_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// Types and constants for the stable priority queue.
package spq_pkg;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int HANDLE_BITS_DEFAULT   = 16;
   localparam int PRIORITY_BITS_DEFAULT = 8;

   localparam int CMD_BITS      = 2;
   localparam int HANDLE_W      = 16;
   localparam int KIND_W        = 4;
   localparam int PRIORITY_W    = 8;
   localparam int STATUS_BITS   = 2;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_APPEND  = 2'd0,
      CMD_INSERT  = 2'd1,
      CMD_DEQUEUE = 2'd2,
      CMD_STATUS  = 2'd3
   } spq_cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } spq_status_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } spq_cell_op_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      spq_cell_op_type op;
      logic            by_priority;
   } spq_ctl_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [HANDLE_W-1:0]   handle;
      logic [KIND_W-1:0]     kind_tag;
      logic [PRIORITY_W-1:0] priority_req;
   } spq_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [HANDLE_W-1:0]      out_handle;
      logic [KIND_W-1:0]        out_kind_tag;
      logic [PRIORITY_W-1:0]    out_priority;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     is_empty;
   } spq_rsp_type;

endpackage

FILE: sv/spq_cell.sv
// One queue slot: holds an entry and trades it with its neighbors.
module spq_cell #(
   parameter int IDX        = 0,
   parameter int COUNT_BITS = 5,
   parameter int HW         = 16,
   parameter int PW         = 8
) (
   input  logic                        clock,
   input  spq_pkg::spq_ctl_type        ctl,
   input  logic [COUNT_BITS-1:0]       count,
   input  logic [HW-1:0]               new_handle,
   input  logic [spq_pkg::KIND_W-1:0]  new_kind,
   input  logic [PW-1:0]               new_prio,
   input  logic                        mark_left,
   input  logic [HW-1:0]               left_handle,
   input  logic [spq_pkg::KIND_W-1:0]  left_kind,
   input  logic [PW-1:0]               left_prio,
   input  logic [HW-1:0]               right_handle,
   input  logic [spq_pkg::KIND_W-1:0]  right_kind,
   input  logic [PW-1:0]               right_prio,
   output logic                        mark,
   output logic [HW-1:0]               handle,
   output logic [spq_pkg::KIND_W-1:0]  kind,
   output logic [PW-1:0]               prio
);

   logic [HW-1:0]              handle_ff, handle_in;
   logic [spq_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [PW-1:0]              prio_ff, prio_in;
   logic                       occupied;
   logic                       lower;

   assign occupied = count > COUNT_BITS'(IDX);
   assign lower    = occupied && (new_prio > prio_ff);

   // mark: the insert point is at or before this slot
   always_comb begin
      if (ctl.by_priority) begin
         mark = mark_left || lower || !occupied;
      end else begin
         mark = !occupied;
      end
   end

   always_comb begin
      handle_in = handle_ff;
      kind_in   = kind_ff;
      prio_in   = prio_ff;
      case (ctl.op)
         spq_pkg::CELL_PUSH: begin
            if (mark_left) begin
               handle_in = left_handle;
               kind_in   = left_kind;
               prio_in   = left_prio;
            end else if (mark) begin
               handle_in = new_handle;
               kind_in   = new_kind;
               prio_in   = new_prio;
            end
         end
         spq_pkg::CELL_POP: begin
            handle_in = right_handle;
            kind_in   = right_kind;
            prio_in   = right_prio;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      kind_ff   <= kind_in;
      prio_ff   <= prio_in;
   end

   assign handle = handle_ff;
   assign kind   = kind_ff;
   assign prio   = prio_ff;

endmodule

FILE: sv/stable_priority_queue_core.sv
// Stable priority queue: request channel in, one response beat per request out.
//
// Requests carry a command (append, insert by priority, dequeue, status), a
// handle, a kind tag and a priority. Insert places the entry ahead of the
// first stored entry of strictly lower priority, so equal priorities keep
// arrival order; append always goes to the tail.
// Every accepted request yields exactly one response beat with the status,
// the dequeued entry (zero unless a dequeue succeeds), the entry count and
// the empty flag. A full queue rejects enqueues, an empty one rejects dequeues.
// Latency: the response is registered and valid the cycle after the request
// beat. Throughput: one request per cycle unless req_stall holds the channel;
// the slots form a row of cells that all compare against the new priority
// in the same cycle, and the insert point ripples from the head along the row.
// Reset empties the queue (entry data is not cleared, only the count).
// While rsp_stall holds a response, req_stall is raised and the request
// channel waits; the response beat holds its payload.
module stable_priority_queue_core #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEFAULT,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spq_pkg::spq_rsp_type rsp_data
);

`include "stable_priority_queue_core_macros.svh"

   localparam int CW = $clog2(DEPTH + 1);
   localparam int HW = (HANDLE_BITS < spq_pkg::HANDLE_W) ? HANDLE_BITS : spq_pkg::HANDLE_W;
   localparam int PW = (PRIORITY_BITS < spq_pkg::PRIORITY_W) ?
                       PRIORITY_BITS : spq_pkg::PRIORITY_W;

   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   spq_pkg::spq_rsp_type rsp_ff, rsp_in;
   spq_pkg::spq_ctl_type ctl;
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 push_go;
   logic                 deq_reject;

   logic [HW-1:0]              handle_a [DEPTH];
   logic [spq_pkg::KIND_W-1:0] kind_a   [DEPTH];
   logic [PW-1:0]              prio_a   [DEPTH];
   logic                       mark_a   [DEPTH];

   logic [HW+spq_pkg::HANDLE_W-1:0]      head_handle_ext;
   logic [PW+spq_pkg::PRIORITY_W-1:0]    head_prio_ext;
   logic [CW+spq_pkg::ENTRY_COUNT_W-1:0] count_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CW'(DEPTH);
   assign empty     = count_ff == '0;

   assign push_go    = accept && !full && (req_data.command == spq_pkg::CMD_APPEND ||
                                           req_data.command == spq_pkg::CMD_INSERT);
   assign deq_reject = accept && empty && req_data.command == spq_pkg::CMD_DEQUEUE;

   assign head_handle_ext = {{spq_pkg::HANDLE_W{1'b0}}, handle_a[0]};
   assign head_prio_ext   = {{spq_pkg::PRIORITY_W{1'b0}}, prio_a[0]};
   assign count_ext       = {{spq_pkg::ENTRY_COUNT_W{1'b0}}, count_in};

   always_comb begin
      ctl.op          = spq_pkg::CELL_HOLD;
      ctl.by_priority = req_data.command == spq_pkg::CMD_INSERT;
      count_in        = count_ff;
      rsp_in          = '0;
      rsp_in.status   = spq_pkg::ST_DONE;
      if (accept) begin
         case (spq_pkg::spq_cmd_type'(req_data.command))
            spq_pkg::CMD_APPEND, spq_pkg::CMD_INSERT: begin
               if (full) begin
                  rsp_in.status = spq_pkg::ST_FULL;
               end else begin
                  ctl.op   = spq_pkg::CELL_PUSH;
                  count_in = count_ff + CW'(1);
               end
            end
            spq_pkg::CMD_DEQUEUE: begin
               if (empty) begin
                  rsp_in.status = spq_pkg::ST_EMPTY;
               end else begin
                  ctl.op              = spq_pkg::CELL_POP;
                  count_in            = count_ff - CW'(1);
                  rsp_in.out_handle   = head_handle_ext[spq_pkg::HANDLE_W-1:0];
                  rsp_in.out_kind_tag = kind_a[0];
                  rsp_in.out_priority = head_prio_ext[spq_pkg::PRIORITY_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      rsp_in.entry_count = count_ext[spq_pkg::ENTRY_COUNT_W-1:0];
      rsp_in.is_empty    = count_in == '0;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                       mark_left;
      logic [HW-1:0]              left_handle, right_handle;
      logic [spq_pkg::KIND_W-1:0] left_kind, right_kind;
      logic [PW-1:0]              left_prio, right_prio;

      if (i == 0) begin : g_head
         assign mark_left   = 1'b0;
         assign left_handle = '0;
         assign left_kind   = '0;
         assign left_prio   = '0;
      end else begin : g_body
         assign mark_left   = mark_a[i-1];
         assign left_handle = handle_a[i-1];
         assign left_kind   = kind_a[i-1];
         assign left_prio   = prio_a[i-1];
      end

      // tail slot refills from itself on a pop; the count drop hides it
      if (i == DEPTH - 1) begin : g_tail
         assign right_handle = handle_a[i];
         assign right_kind   = kind_a[i];
         assign right_prio   = prio_a[i];
      end else begin : g_mid
         assign right_handle = handle_a[i+1];
         assign right_kind   = kind_a[i+1];
         assign right_prio   = prio_a[i+1];
      end

      spq_cell #(
         .IDX        (i),
         .COUNT_BITS (CW),
         .HW         (HW),
         .PW         (PW)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .count        (count_ff),
         .new_handle   (req_data.handle[HW-1:0]),
         .new_kind     (req_data.kind_tag),
         .new_prio     (req_data.priority_req[PW-1:0]),
         .mark_left    (mark_left),
         .left_handle  (left_handle),
         .left_kind    (left_kind),
         .left_prio    (left_prio),
         .right_handle (right_handle),
         .right_kind   (right_kind),
         .right_prio   (right_prio),
         .mark         (mark_a[i]),
         .handle       (handle_a[i]),
         .kind         (kind_a[i]),
         .prio         (prio_a[i])
      );
   end

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "entry count above depth")
   `SPQ_ASSERT_NOW(a_empty_flag, rsp_valid_ff, rsp_ff.is_empty == empty, "empty flag mismatch")
   `SPQ_ASSERT_NEXT(a_push_count, push_go, count_ff == $past(count_ff) + CW'(1), "enqueue lost")
   `SPQ_ASSERT_NEXT(a_empty_reject, deq_reject, rsp_ff.status == spq_pkg::ST_EMPTY && empty, "no reject")

endmodule
